/* rtl/prtb_pkg.sv */
// shared constants and types for the pulse run to byte decoder
`default_nettype none

package prtb_pkg;

    localparam int DUR_W       = 15;
    localparam int RUN_W       = 16;
    localparam int NUM_W       = RUN_W + 1;
    localparam int BYTE_W      = 8;
    localparam int BCNT_W      = 3;
    localparam int KBITS_W     = BCNT_W + 1;
    localparam int MAX_RESULTS = 32;
    localparam int RCNT_W      = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int PERIOD_W    = 8;
    localparam int GLITCH_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_MAX = 2'd2;

    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST = 8'd35;
    localparam logic [RUN_W-1:0]    MIN_RUN_RST    = 16'd10;
    localparam logic [GLITCH_W-1:0] GLITCH_MAX_RST = 8'd3;

    typedef logic [RUN_W-1:0]    run_t;
    typedef logic [NUM_W-1:0]    numer_t;
    typedef logic [PERIOD_W-1:0] period_t;
    typedef logic [BYTE_W-1:0]   byte_t;

    typedef struct packed {
        logic   start;
        numer_t numer;
        period_t divisor;
    } div_req_t;

    typedef struct packed {
        logic   done;
        numer_t quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/prtb_div.sv */
// restoring divider, one quotient bit per cycle
`default_nettype none

module prtb_div
    import prtb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   steps_reg, steps_next;
    numer_t              quo_reg, quo_next;
    period_t             rem_reg, rem_next;
    period_t             div_reg, div_next;
    logic [PERIOD_W+1:0] trial;
    logic [PERIOD_W:0]   partial;
    logic                fits;

    always_comb
    begin
        partial = {rem_reg, quo_reg[NUM_W-1]};
        trial   = {1'b0, partial} - {2'b00, div_reg};
        fits    = ~trial[PERIOD_W+1];

        busy_next  = busy_reg;
        done_next  = 1'b0;
        steps_next = steps_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;

        if (req.start)
        begin
            busy_next  = 1'b1;
            steps_next = STEP_W'(NUM_W);
            quo_next   = req.numer;
            rem_next   = '0;
            div_next   = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next   = {quo_reg[NUM_W-2:0], fits};
            rem_next   = fits ? trial[PERIOD_W-1:0] : partial[PERIOD_W-1:0];
            steps_next = steps_reg - STEP_W'(1);
            if (steps_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            steps_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            steps_reg <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

/* rtl/pulse_run_to_byte_decoder.sv */
// pulse run to byte decoder top level: run tracking, bit slicing and byte output
// a pulse that does not close a run is absorbed in idle; the next item is taken right after
// a pulse that closes a run of at least min_run ticks starts the divider (ST_DIV), then the
// run's bits are packed into the current byte one group at a time, each group filling it as
// far as it goes (ST_EMIT, held while the output is stalled); input stalls until back in idle
// bytes leave through registered outputs (out_valid, data_byte, last) as emit fills them
// reset clears all run state and loads the register defaults 35, 10 and 3
`default_nettype none

module pulse_run_to_byte_decoder
    import prtb_pkg::*;
#(
    parameter int RUN_BITS_MAX = 255
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  start_packet,
    input  wire logic                  level,
    input  wire logic [DUR_W-1:0]      duration,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [BYTE_W-1:0]          data_byte,
    output logic                       last,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int RB_W = $clog2(RUN_BITS_MAX + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]        state_reg, state_next;
    period_t           bit_period_reg;
    run_t              min_run_reg;
    logic [GLITCH_W-1:0] glitch_max_reg;

    logic              have_run_reg, have_run_next;
    logic              run_level_reg, run_level_next;
    run_t              run_length_reg, run_length_next;
    byte_t             shift_byte_reg, shift_byte_next;
    logic [BCNT_W-1:0] bit_count_reg, bit_count_next;
    logic              emit_level_reg, emit_level_next;
    logic [RB_W-1:0]   rem_bits_reg, rem_bits_next;
    logic [RCNT_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic              out_valid_reg, out_valid_next;
    byte_t             data_byte_reg, data_byte_next;
    logic              last_reg, last_next;

    logic              in_fire;
    logic              sp_have;
    logic              sp_level;
    run_t              sp_len;
    numer_t            run_sum;
    period_t           period_eff;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic [KBITS_W-1:0] space;
    logic [KBITS_W-1:0] kbits;
    logic [KBITS_W-1:0] count_sum;
    byte_t              shifted;
    byte_t              fill;
    byte_t              new_byte;
    logic [RB_W-1:0]    rem_after;
    logic               full;
    logic               report;
    logic               emit_hold;

    prtb_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= BIT_PERIOD_RST;
            min_run_reg    <= MIN_RUN_RST;
            glitch_max_reg <= GLITCH_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BIT_PERIOD: bit_period_reg <= cfg_data[PERIOD_W-1:0];
                CFG_MIN_RUN:    min_run_reg    <= cfg_data[RUN_W-1:0];
                CFG_GLITCH_MAX: glitch_max_reg <= cfg_data[GLITCH_W-1:0];
                default:        ;
            endcase
        end
    end

    assign period_eff = (bit_period_reg == '0) ? period_t'(1) : bit_period_reg;

    always_comb
    begin
        sp_have  = start_packet ? 1'b0 : have_run_reg;
        sp_level = start_packet ? 1'b0 : run_level_reg;
        sp_len   = start_packet ? '0 : run_length_reg;
        run_sum  = {1'b0, sp_len} + numer_t'(duration);

        space     = KBITS_W'(BYTE_W) - {1'b0, bit_count_reg};
        kbits     = (rem_bits_reg >= RB_W'(space)) ? space : KBITS_W'(rem_bits_reg);
        shifted   = shift_byte_reg << kbits;
        fill      = ~(8'hFF << kbits);
        new_byte  = shifted | (emit_level_reg ? fill : '0);
        count_sum = {1'b0, bit_count_reg} + kbits;
        full      = count_sum[BCNT_W];
        rem_after = rem_bits_reg - RB_W'(kbits);
        report    = full && (byte_cnt_reg < RCNT_W'(MAX_RESULTS));
        emit_hold = report && out_valid_reg && out_stall;

        div_req.start   = 1'b0;
        div_req.numer   = {1'b0, sp_len} + numer_t'(period_eff[PERIOD_W-1:1]);
        div_req.divisor = period_eff;

        state_next      = state_reg;
        have_run_next   = have_run_reg;
        run_level_next  = run_level_reg;
        run_length_next = run_length_reg;
        shift_byte_next = shift_byte_reg;
        bit_count_next  = bit_count_reg;
        emit_level_next = emit_level_reg;
        rem_bits_next   = rem_bits_reg;
        byte_cnt_next   = byte_cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        data_byte_next  = data_byte_reg;
        last_next       = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    have_run_next   = sp_have;
                    run_level_next  = sp_level;
                    run_length_next = sp_len;
                    if (start_packet)
                    begin
                        shift_byte_next = '0;
                        bit_count_next  = '0;
                    end
                    if (duration != '0)
                    begin
                        if (!sp_have)
                        begin
                            have_run_next   = 1'b1;
                            run_level_next  = level;
                            run_length_next = run_t'(duration);
                        end
                        else if (level == sp_level ||
                                 {1'b0, duration} < RUN_W'(glitch_max_reg))
                        begin
                            run_length_next = run_sum[RUN_W] ? '1 : run_sum[RUN_W-1:0];
                        end
                        else
                        begin
                            if (sp_len >= min_run_reg)
                            begin
                                div_req.start   = 1'b1;
                                emit_level_next = sp_level;
                                state_next      = ST_DIV;
                            end
                            run_level_next  = level;
                            run_length_next = run_t'(duration);
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    byte_cnt_next = '0;
                    if (div_rsp.quotient > NUM_W'(RUN_BITS_MAX))
                        rem_bits_next = RB_W'(RUN_BITS_MAX);
                    else
                        rem_bits_next = div_rsp.quotient[RB_W-1:0];
                    if (div_rsp.quotient == '0)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!emit_hold)
                begin
                    rem_bits_next = rem_after;
                    if (full)
                    begin
                        shift_byte_next = '0;
                        bit_count_next  = '0;
                        if (report)
                        begin
                            out_valid_next = 1'b1;
                            data_byte_next = new_byte;
                            last_next      = (rem_after < RB_W'(BYTE_W)) ||
                                             (byte_cnt_reg == RCNT_W'(MAX_RESULTS - 1));
                            byte_cnt_next  = byte_cnt_reg + RCNT_W'(1);
                        end
                    end
                    else
                    begin
                        shift_byte_next = new_byte;
                        bit_count_next  = count_sum[BCNT_W-1:0];
                    end
                    if (rem_after == '0)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            have_run_reg   <= 1'b0;
            run_level_reg  <= 1'b0;
            run_length_reg <= '0;
            shift_byte_reg <= '0;
            bit_count_reg  <= '0;
            emit_level_reg <= 1'b0;
            rem_bits_reg   <= '0;
            byte_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            have_run_reg   <= have_run_next;
            run_level_reg  <= run_level_next;
            run_length_reg <= run_length_next;
            shift_byte_reg <= shift_byte_next;
            bit_count_reg  <= bit_count_next;
            emit_level_reg <= emit_level_next;
            rem_bits_reg   <= rem_bits_next;
            byte_cnt_reg   <= byte_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_byte_reg <= data_byte_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign data_byte = data_byte_reg;
    assign last      = last_reg;

    a_emit_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> rem_bits_reg != '0)
        else $error("emit state with no bits left");

    a_byte_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_cnt_reg <= RCNT_W'(MAX_RESULTS))
        else $error("byte count beyond result limit");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider finished outside divide state");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> state_reg == ST_DIV)
        else $error("divide started without entering divide state");

endmodule

`default_nettype wire

/* test/run_byte_checker.sv */
// checker for the pulse run to byte decoder: tracks runs, predicts bytes and compares them
module run_byte_checker
    import prtb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic                  start_packet,
    input  wire logic                  level,
    input  wire logic [DUR_W-1:0]      duration,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic [BYTE_W-1:0]     data_byte,
    input  wire logic                  last,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_BITS_MAX = 255;

    typedef struct packed {
        byte_t data;
        logic  last;
    } sliced_byte_t;

    sliced_byte_t expected_bytes[$];
    sliced_byte_t want;

    period_t               bit_period;
    run_t                  min_run;
    logic [GLITCH_W-1:0]   glitch_max;

    logic  have_run;
    logic  run_level;
    run_t  run_length;
    byte_t shift_byte;
    int    bits_held;
    int    mismatches = 0;

    task automatic clear_run();
        have_run   = 1'b0;
        run_level  = 1'b0;
        run_length = '0;
        shift_byte = '0;
        bits_held  = 0;
    endtask

    task automatic slice_run_bits();
        int unsigned  period;
        int unsigned  nbits;
        int           produced;
        sliced_byte_t item;
        if (run_length < min_run)
            return;
        period = (bit_period == 0) ? 1 : bit_period;
        nbits = (run_length + period / 2) / period;
        if (nbits > RUN_BITS_MAX)
            nbits = RUN_BITS_MAX;
        produced = 0;
        for (int b = 0; b < nbits; b++)
        begin
            shift_byte = {shift_byte[BYTE_W-2:0], run_level};
            bits_held++;
            if (bits_held == BYTE_W)
            begin
                if (produced < MAX_RESULTS)
                begin
                    item.data = shift_byte;
                    item.last = 1'b0;
                    expected_bytes.push_back(item);
                    produced++;
                end
                shift_byte = '0;
                bits_held  = 0;
            end
        end
        if (produced > 0)
        begin
            item = expected_bytes.pop_back();
            item.last = 1'b1;
            expected_bytes.push_back(item);
        end
    endtask

    task automatic track_pulse(input logic sp, input logic lv, input logic [DUR_W-1:0] dur);
        int sum;
        if (sp)
            clear_run();
        if (dur == 0)
            return;
        if (!have_run)
        begin
            have_run   = 1'b1;
            run_level  = lv;
            run_length = run_t'(dur);
        end
        else if (lv == run_level || dur < glitch_max)
        begin
            sum = run_length + dur;
            if (sum > 65535)
                sum = 65535;
            run_length = sum[RUN_W-1:0];
        end
        else
        begin
            slice_run_bits();
            run_level  = lv;
            run_length = run_t'(dur);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period = BIT_PERIOD_RST;
            min_run    = MIN_RUN_RST;
            glitch_max = GLITCH_MAX_RST;
            clear_run();
            expected_bytes.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected byte %02h last %0b", data_byte, last);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (data_byte !== want.data || last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                                     want.data, want.last, data_byte, last);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BIT_PERIOD: bit_period = cfg_data[PERIOD_W-1:0];
                    CFG_MIN_RUN:    min_run    = cfg_data[RUN_W-1:0];
                    CFG_GLITCH_MAX: glitch_max = cfg_data[GLITCH_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                track_pulse(start_packet, level, duration);
            pending    <= expected_bytes.size();
            fail_count <= mismatches;
        end
    end

endmodule

/* test/tb.sv */
// testbench top for the pulse run to byte decoder: clock, reset, stimulus and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prtb_pkg::*;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  start_packet = 1'b0;
    logic                  level        = 1'b0;
    logic [DUR_W-1:0]      duration     = '0;
    logic                  out_stall    = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_BIT_PERIOD;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    wire logic              in_stall;
    wire logic              out_valid;
    wire logic [BYTE_W-1:0] data_byte;
    wire logic              last;
    wire logic              cfg_ready;

    int fail_count;
    int pending;

    int   burst_left = 0;
    int   stall_mode = 0;
    int   stall_left = 0;
    logic line_level = 1'b0;

    always #1 clk = ~clk;

    pulse_run_to_byte_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .start_packet (start_packet),
        .level        (level),
        .duration     (duration),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data_byte    (data_byte),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    run_byte_checker byte_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .start_packet (start_packet),
        .level        (level),
        .duration     (duration),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data_byte    (data_byte),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 150);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= ((stall_left % 16) < 10);
        endcase
    end

    task automatic send_pulse(input logic sp, input logic lv, input int dur);
        in_valid     <= 1'b1;
        start_packet <= sp;
        level        <= lv;
        duration     <= dur[DUR_W-1:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
            burst_left = $urandom_range(0, 10);
        end
        else
            burst_left--;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (80)
            @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_config(input int period, input int min_len, input int glitch);
        wait_idle();
        put_reg(CFG_BIT_PERIOD, {8'($urandom), 8'(period)});
        put_reg(CFG_MIN_RUN, 16'(min_len));
        put_reg(CFG_GLITCH_MAX, {8'($urandom), 8'(glitch)});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_pulse(input int period, input int glitch);
        int p;
        int dur;
        int pick;
        p = (period == 0) ? 1 : period;
        pick = $urandom_range(0, 99);
        if (pick < 74)
        begin
            line_level = ~line_level;
            dur = p * $urandom_range(1, 6) + $urandom_range(0, p / 2) - p / 4;
            if (dur < 1)
                dur = 1;
            if (dur > 32767)
                dur = 32767;
            send_pulse(pick < 4, line_level, dur);
        end
        else if (pick < 82)
            send_pulse(1'b0, ~line_level, $urandom_range(1, glitch + 1));
        else if (pick < 90)
            send_pulse(1'b0, line_level, $urandom_range(1, 2 * p));
        else if (pick < 94)
            send_pulse(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 0);
        else
        begin
            line_level = 1'($urandom_range(0, 1));
            send_pulse(1'($urandom_range(0, 1)), line_level, $urandom_range(0, 32767));
        end
    endtask

    initial
    begin
        int period;
        int min_len;
        int glitch;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        // defaults: empty start, ignored pulse, merge, glitch, drop, saturation
        send_pulse(1'b1, 1'b1, 0);
        send_pulse(1'b0, 1'b0, 0);
        send_pulse(1'b0, 1'b1, 350);
        send_pulse(1'b0, 1'b1, 1);
        send_pulse(1'b0, 1'b0, 2);
        send_pulse(1'b0, 1'b0, 280);
        send_pulse(1'b0, 1'b1, 5);
        send_pulse(1'b0, 1'b0, 40);
        send_pulse(1'b0, 1'b1, 32767);
        send_pulse(1'b0, 1'b1, 32767);
        send_pulse(1'b0, 1'b1, 32767);
        send_pulse(1'b0, 1'b0, 100);
        send_pulse(1'b1, 1'b0, 1);
        send_pulse(1'b0, 1'b1, 32767);
        send_pulse(1'b0, 1'b0, 35);

        set_config(1, 0, 0);
        send_pulse(1'b1, 1'b0, 32767);
        send_pulse(1'b0, 1'b0, 32767);
        send_pulse(1'b0, 1'b0, 32767);
        send_pulse(1'b0, 1'b1, 1);
        send_pulse(1'b0, 1'b0, 1);

        // zero period acts as one, longest minimum run
        set_config(0, 65535, 0);
        send_pulse(1'b1, 1'b1, 32767);
        send_pulse(1'b0, 1'b1, 32767);
        send_pulse(1'b0, 1'b1, 1);
        send_pulse(1'b0, 1'b0, 5);

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    period = 35;  min_len = 10; glitch = 3;
                end
                1:
                begin
                    period = 255; min_len = 0;  glitch = 255;
                end
                2:
                begin
                    period = 8;   min_len = 4;  glitch = 2;
                end
                3:
                begin
                    period = $urandom_range(1, 255);
                    min_len = $urandom_range(0, 200);
                    glitch = $urandom_range(0, 20);
                end
                4:
                begin
                    period = 1;   min_len = 0;  glitch = 0;
                end
                default:
                begin
                    period = 100; min_len = 50; glitch = 20;
                end
            endcase
            set_config(period, min_len, glitch);
            for (int i = 0; i < 33; i++)
            begin
                if (ph == 3 && i == 18)
                    wait_idle();
                send_random_pulse(period, glitch);
            end
        end

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #1_500_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
